@@ rtl/core/kmeans_2d_grid_snap_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the k-means grid snap block
// Checks are clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KMEANS_2D_GRID_SNAP_ASSERT_SVH
`define KMEANS_2D_GRID_SNAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmgs same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KMGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmgs next-cycle check failed");

`endif

@@ rtl/core/kmgs_pkg.sv @@
// ----------------------------------------------------------------------------
// kmgs_pkg
// Shared types and codes for the k-means grid snap block.
// ----------------------------------------------------------------------------
package kmgs_pkg;

  localparam int COORD_W = 24;
  localparam int DIST_W  = 50;
  localparam int IDX_W   = 6;

  localparam logic [1:0] OP_LOAD_POINT    = 2'd0;
  localparam logic [1:0] OP_LOAD_CENTROID = 2'd1;
  localparam logic [1:0] OP_START         = 2'd2;
  localparam logic [1:0] OP_RESERVED      = 2'd3;

  localparam logic [2:0] REG_NUM_CLUSTERS = 3'd0;
  localparam logic [2:0] REG_EPOCHS       = 3'd1;
  localparam logic [2:0] REG_SNAP_MODE    = 3'd2;
  localparam logic [2:0] REG_GRID_STEP    = 3'd3;
  localparam logic [2:0] REG_MIN_SIZE     = 3'd4;

  localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

  // A point travelling along the cell chain with its best match so far.
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         dist_min;
    logic [IDX_W-1:0]          idx;
  } kmgs_pt_t;

endpackage

@@ rtl/core/kmgs_in_if.sv @@
// ----------------------------------------------------------------------------
// kmgs_in_if
// Input word channel: opcode and one coordinate pair.
// ----------------------------------------------------------------------------
interface kmgs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [23:0] coord_x;
  logic signed [23:0] coord_y;

  modport source (output valid, output opcode, output coord_x, output coord_y, input ready);
  modport sink (input valid, input opcode, input coord_x, input coord_y, output ready);
endinterface

@@ rtl/core/kmgs_out_if.sv @@
// ----------------------------------------------------------------------------
// kmgs_out_if
// Result word channel: one final centroid with its member count.
// ----------------------------------------------------------------------------
interface kmgs_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         cluster_index;
  logic signed [23:0] centroid_x;
  logic signed [23:0] centroid_y;
  logic [16:0]        member_count;
  logic               deleted;
  logic               last;

  modport source (output valid, output cluster_index, output centroid_x, output centroid_y,
                  output member_count, output deleted, output last, input ready);
  modport sink (input valid, input cluster_index, input centroid_x, input centroid_y,
                input member_count, input deleted, input last, output ready);
endinterface

@@ rtl/core/kmgs_cell.sv @@
// ----------------------------------------------------------------------------
// kmgs_cell
// One cluster cell: holds a centroid, compares passing points against it
// and accumulates the points finally assigned to it.
// ----------------------------------------------------------------------------
module kmgs_cell #(
  parameter int IDX   = 0,
  parameter int SUM_W = 41,
  parameter int CNT_W = 17
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      active,
  input  kmgs_pkg::kmgs_pt_t        pt_i,
  output kmgs_pkg::kmgs_pt_t        pt_o,
  input  kmgs_pkg::kmgs_pt_t        acc_i,
  input  logic                      clr,
  input  logic                      cen_we,
  input  logic signed [23:0]        cen_x_i,
  input  logic signed [23:0]        cen_y_i,
  output logic signed [23:0]        cen_x_o,
  output logic signed [23:0]        cen_y_o,
  output logic signed [SUM_W-1:0]   sum_x_o,
  output logic signed [SUM_W-1:0]   sum_y_o,
  output logic [CNT_W-1:0]          tally_o
);

  logic signed [23:0]       cx_r, cy_r;
  kmgs_pkg::kmgs_pt_t       s1_pt_r, s2_pt_r, s2_pt_nxt;
  logic [48:0]              sqx_r, sqy_r;
  logic signed [24:0]       dx, dy;
  logic signed [49:0]       sqx_full, sqy_full;
  logic [49:0]              sq_sum;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic [CNT_W-1:0]         tally_r;

  assign dx       = {pt_i.x[23], pt_i.x} - {cx_r[23], cx_r};
  assign dy       = {pt_i.y[23], pt_i.y} - {cy_r[23], cy_r};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign sq_sum   = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    s2_pt_nxt = s1_pt_r;
    if (active && s1_pt_r.valid && (sq_sum < s1_pt_r.dist_min)) begin
      s2_pt_nxt.dist_min = sq_sum;
      s2_pt_nxt.idx      = kmgs_pkg::IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pt_r <= '0;
      s2_pt_r <= '0;
    end else begin
      s1_pt_r <= pt_i;
      s2_pt_r <= s2_pt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r <= sqx_full[48:0];
    sqy_r <= sqy_full[48:0];
    if (cen_we) begin
      cx_r <= cen_x_i;
      cy_r <= cen_y_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      tally_r <= '0;
    end else if (clr) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      tally_r <= '0;
    end else if (acc_i.valid && (acc_i.idx == kmgs_pkg::IDX_W'(IDX))) begin
      sum_x_r <= sum_x_r + {{(SUM_W-24){acc_i.x[23]}}, acc_i.x};
      sum_y_r <= sum_y_r + {{(SUM_W-24){acc_i.y[23]}}, acc_i.y};
      tally_r <= tally_r + CNT_W'(1);
    end
  end

  assign pt_o    = s2_pt_r;
  assign cen_x_o = cx_r;
  assign cen_y_o = cy_r;
  assign sum_x_o = sum_x_r;
  assign sum_y_o = sum_y_r;
  assign tally_o = tally_r;

endmodule

@@ rtl/core/kmgs_divider.sv @@
// ----------------------------------------------------------------------------
// kmgs_divider
// Serial signed-by-unsigned divider, one quotient bit per cycle. The
// quotient truncates toward zero and the remainder takes the dividend sign.
// ----------------------------------------------------------------------------
module kmgs_divider #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot,
  output logic signed [DEN_W:0]   rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   r_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;

  assign trial = {r_r[DEN_W-1:0], q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        r_r <= trial - {1'b0, den_r};
        q_r <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        r_r <= trial;
        q_r <= {q_r[NUM_W-2:0], 1'b0};
      end
    end else if (start) begin
      neg_r <= num[NUM_W-1];
      q_r   <= num[NUM_W-1] ? NUM_W'(-num) : num;
      r_r   <= '0;
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
  assign rem  = neg_r ? -$signed(r_r) : $signed(r_r);

endmodule

@@ rtl/core/kmeans_2d_grid_snap.sv @@
// ----------------------------------------------------------------------------
// kmeans_2d_grid_snap
// Load words are accepted only while idle, one per cycle. A start word runs
// each epoch as an assignment pass of all points through the cell chain,
// then visits each cluster in turn; a non-empty one gets 2 to 4 serial
// divisions (mean x, mean y, optional snap x and y) and a centroid write.
// K result words follow, one per cycle while the receiver is ready.
// Synchronous reset restores configuration defaults and clears counts.
// ----------------------------------------------------------------------------
`include "kmeans_2d_grid_snap_assert.svh"

module kmeans_2d_grid_snap #(
  parameter int MAX_POINTS   = 65536,
  parameter int MAX_CLUSTERS = 64,
  parameter int FRAC_BITS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  kmgs_in_if.sink     in_ch,
  kmgs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PA_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 24 + PA_W + 1;
  localparam int DEN_W = (CNT_W > 16) ? CNT_W : 16;
  localparam int SN_W  = ((DEN_W + FRAC_BITS + 3) > 27) ? (DEN_W + FRAC_BITS + 3) : 27;
  localparam int IF_W  = $clog2(2 * MAX_CLUSTERS + 3);
  localparam int CI_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int MW    = (CNT_W > 17) ? CNT_W : 17;
  localparam logic [23:0] NEG_ONE = 24'(-(32'sd1 <<< FRAC_BITS));
  localparam logic signed [SN_W-1:0] SAT_HI = SN_W'(8388607);
  localparam logic signed [SN_W-1:0] SAT_LO = -SN_W'(8388608);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_ASSIGN = 11'b00000000010,
    S_DRAIN  = 11'b00000000100,
    S_UPD    = 11'b00000001000,
    S_DIVX   = 11'b00000010000,
    S_DIVY   = 11'b00000100000,
    S_SNAPX  = 11'b00001000000,
    S_SNAPY  = 11'b00010000000,
    S_WRITE  = 11'b00100000000,
    S_NEXT   = 11'b01000000000,
    S_REPORT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]  num_clusters_r;
  logic [7:0]  epochs_r;
  logic [1:0]  snap_mode_r;
  logic [15:0] grid_step_r;
  logic [16:0] min_size_r;

  logic [CNT_W-1:0] point_total_r, rd_ptr_r, rd_ptr_nxt;
  logic [6:0]       cen_loaded_r;
  logic [7:0]       epoch_cnt_r, epoch_cnt_nxt;
  logic [CI_W-1:0]  c_r, c_nxt;
  logic [IF_W-1:0]  inflight_r;
  logic signed [23:0] mx_r, my_r, mx_nxt, my_nxt;

  logic [47:0] pmem [MAX_POINTS];
  logic [47:0] rd_data_r;
  logic        rd_vld_r;

  logic in_fire, cfg_we, issue, clr, k_is_last;
  logic [6:0] k_eff, k_last;

  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0]        div_den;
  logic signed [DEN_W:0]   div_rem;

  logic                    out_valid_r, out_load;
  logic [5:0]              out_idx_r;
  logic signed [23:0]      out_x_r, out_y_r;
  logic [16:0]             out_cnt_r;
  logic                    out_del_r, out_last_r, sel_del;

  kmgs_pkg::kmgs_pt_t chain [MAX_CLUSTERS+1];
  logic signed [23:0]      cell_cx [MAX_CLUSTERS];
  logic signed [23:0]      cell_cy [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] cell_sx [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] cell_sy [MAX_CLUSTERS];
  logic [CNT_W-1:0]        cell_tally [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] cen_we;
  logic signed [23:0]      cen_wx, cen_wy;
  logic                    load_cen, snap_ok;
  logic [MW-1:0]           sel_tally_w;

  function automatic logic signed [SUM_W-1:0] int_part(input logic signed [23:0] v);
    logic signed [SUM_W-1:0] e;
    e = {{(SUM_W-24){v[23]}}, v};
    if (v[23]) begin
      int_part = -((-e) >>> FRAC_BITS);
    end else begin
      int_part = e >>> FRAC_BITS;
    end
  endfunction

  function automatic logic signed [23:0] snap_val(input logic signed [23:0] v,
                                                  input logic signed [DEN_W:0] r,
                                                  input logic [15:0] step);
    logic signed [SN_W-1:0] o, re, st;
    re = {{(SN_W-DEN_W-1){r[DEN_W]}}, r};
    st = {{(SN_W-16){1'b0}}, step};
    o  = {{(SN_W-24){v[23]}}, v} - (re <<< FRAC_BITS);
    if ((re <<< 1) > st) begin
      o = o + (st <<< FRAC_BITS);
    end
    if (o > SAT_HI) begin
      o = SAT_HI;
    end else if (o < SAT_LO) begin
      o = SAT_LO;
    end
    snap_val = o[23:0];
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= 7'd64;
      epochs_r       <= 8'd10;
      snap_mode_r    <= 2'd1;
      grid_step_r    <= 16'd150;
      min_size_r     <= 17'd20;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        kmgs_pkg::REG_NUM_CLUSTERS: num_clusters_r <= pwdata[6:0];
        kmgs_pkg::REG_EPOCHS:       epochs_r       <= pwdata[7:0];
        kmgs_pkg::REG_SNAP_MODE:    snap_mode_r    <= pwdata[1:0];
        kmgs_pkg::REG_GRID_STEP:    grid_step_r    <= pwdata[15:0];
        kmgs_pkg::REG_MIN_SIZE:     min_size_r     <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      kmgs_pkg::REG_NUM_CLUSTERS: prdata = {25'd0, num_clusters_r};
      kmgs_pkg::REG_EPOCHS:       prdata = {24'd0, epochs_r};
      kmgs_pkg::REG_SNAP_MODE:    prdata = {30'd0, snap_mode_r};
      kmgs_pkg::REG_GRID_STEP:    prdata = {16'd0, grid_step_r};
      kmgs_pkg::REG_MIN_SIZE:     prdata = {15'd0, min_size_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign k_eff = (num_clusters_r == 7'd0) ? 7'd1 :
                 (num_clusters_r > 7'(MAX_CLUSTERS)) ? 7'(MAX_CLUSTERS) : num_clusters_r;
  assign k_last    = k_eff - 7'd1;
  assign k_is_last = (7'(c_r) == k_last);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_cen    = in_fire && (in_ch.opcode == kmgs_pkg::OP_LOAD_CENTROID) &&
                       (cen_loaded_r < 7'(MAX_CLUSTERS));

  // Point store.
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.opcode == kmgs_pkg::OP_LOAD_POINT) &&
        (point_total_r < CNT_W'(MAX_POINTS))) begin
      pmem[point_total_r[PA_W-1:0]] <= {in_ch.coord_x, in_ch.coord_y};
    end
    if (issue) begin
      rd_data_r <= pmem[rd_ptr_r[PA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_total_r <= '0;
      cen_loaded_r  <= '0;
    end else begin
      if (in_fire && (in_ch.opcode == kmgs_pkg::OP_LOAD_POINT) &&
          (point_total_r < CNT_W'(MAX_POINTS))) begin
        point_total_r <= point_total_r + CNT_W'(1);
      end
      if (load_cen) begin
        cen_loaded_r <= cen_loaded_r + 7'd1;
      end
    end
  end

  assign issue = (state_r == S_ASSIGN) && (rd_ptr_r < point_total_r);

  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = rd_vld_r;
    chain[0].x        = rd_data_r[47:24];
    chain[0].y        = rd_data_r[23:0];
    chain[0].dist_min = kmgs_pkg::DIST_ALL_ONES;
  end

  assign cen_wx = load_cen ? in_ch.coord_x : mx_r;
  assign cen_wy = load_cen ? in_ch.coord_y : my_r;

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    assign cen_we[i] = (load_cen && (cen_loaded_r == 7'(i))) ||
                       ((state_r == S_WRITE) && (c_r == CI_W'(i)));
    kmgs_cell #(.IDX(i), .SUM_W(SUM_W), .CNT_W(CNT_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (7'(i) < k_eff),
      .pt_i    (chain[i]),
      .pt_o    (chain[i+1]),
      .acc_i   (chain[MAX_CLUSTERS]),
      .clr     (clr),
      .cen_we  (cen_we[i]),
      .cen_x_i (cen_wx),
      .cen_y_i (cen_wy),
      .cen_x_o (cell_cx[i]),
      .cen_y_o (cell_cy[i]),
      .sum_x_o (cell_sx[i]),
      .sum_y_o (cell_sy[i]),
      .tally_o (cell_tally[i])
    );
  end

  kmgs_divider #(.NUM_W(SUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign snap_ok     = (grid_step_r != 16'd0);
  assign sel_tally_w = MW'(cell_tally[c_r]);
  assign sel_del     = sel_tally_w < MW'(min_size_r);
  assign out_load    = (state_r == S_REPORT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    epoch_cnt_nxt = epoch_cnt_r;
    c_nxt         = c_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    clr           = 1'b0;
    div_start     = 1'b0;
    div_num       = cell_sx[c_r];
    div_den       = DEN_W'(cell_tally[c_r]);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.opcode == kmgs_pkg::OP_START)) begin
          clr           = 1'b1;
          rd_ptr_nxt    = '0;
          epoch_cnt_nxt = '0;
          c_nxt         = '0;
          state_nxt     = (epochs_r == 8'd0) ? S_REPORT : S_ASSIGN;
        end
      end
      S_ASSIGN: begin
        if (issue) begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if ((inflight_r == '0) && !rd_vld_r) begin
          c_nxt     = '0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (cell_tally[c_r] != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIVX;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          mx_nxt    = div_quot[23:0];
          div_num   = cell_sy[c_r];
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          my_nxt  = div_quot[23:0];
          div_den = DEN_W'(grid_step_r);
          if (snap_mode_r[0] && snap_ok) begin
            div_num   = int_part(mx_r);
            div_start = 1'b1;
            state_nxt = S_SNAPX;
          end else if (snap_mode_r[1] && snap_ok) begin
            div_num   = int_part(div_quot[23:0]);
            div_start = 1'b1;
            state_nxt = S_SNAPY;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_SNAPX: begin
        div_den = DEN_W'(grid_step_r);
        if (div_done) begin
          mx_nxt = snap_val(mx_r, div_rem, grid_step_r);
          if (snap_mode_r[1]) begin
            div_num   = int_part(my_r);
            div_start = 1'b1;
            state_nxt = S_SNAPY;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_SNAPY: begin
        if (div_done) begin
          my_nxt    = snap_val(my_r, div_rem, grid_step_r);
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (k_is_last) begin
          c_nxt = '0;
          if (epoch_cnt_r == (epochs_r - 8'd1)) begin
            state_nxt = S_REPORT;
          end else begin
            epoch_cnt_nxt = epoch_cnt_r + 8'd1;
            clr           = 1'b1;
            rd_ptr_nxt    = '0;
            state_nxt     = S_ASSIGN;
          end
        end else begin
          c_nxt     = c_r + CI_W'(1);
          state_nxt = S_UPD;
        end
      end
      S_REPORT: begin
        if (out_load) begin
          if (k_is_last) begin
            state_nxt = S_IDLE;
          end else begin
            c_nxt = c_r + CI_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      epoch_cnt_r <= '0;
      c_r         <= '0;
      rd_vld_r    <= 1'b0;
      inflight_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      epoch_cnt_r <= epoch_cnt_nxt;
      c_r         <= c_nxt;
      rd_vld_r    <= issue;
      if (issue && !chain[MAX_CLUSTERS].valid) begin
        inflight_r <= inflight_r + IF_W'(1);
      end else if (!issue && chain[MAX_CLUSTERS].valid) begin
        inflight_r <= inflight_r - IF_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;
    my_r <= my_nxt;
    if (out_load) begin
      out_idx_r  <= 6'(c_r);
      out_x_r    <= sel_del ? NEG_ONE : cell_cx[c_r];
      out_y_r    <= sel_del ? NEG_ONE : cell_cy[c_r];
      out_cnt_r  <= sel_tally_w[16:0];
      out_del_r  <= sel_del;
      out_last_r <= k_is_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cluster_index = out_idx_r;
  assign out_ch.centroid_x    = out_x_r;
  assign out_ch.centroid_y    = out_y_r;
  assign out_ch.member_count  = out_cnt_r;
  assign out_ch.deleted       = out_del_r;
  assign out_ch.last          = out_last_r;

  `KMGS_ASSERT_IMP(a_report_drained, state_r == S_REPORT, inflight_r == '0)
  `KMGS_ASSERT_IMP(a_label_in_range, chain[MAX_CLUSTERS].valid, 7'(chain[MAX_CLUSTERS].idx) < k_eff)
  `KMGS_ASSERT_NXT(a_start_leaves_idle, in_fire && (in_ch.opcode == kmgs_pkg::OP_START), state_r != S_IDLE)
  `KMGS_ASSERT_IMP(a_last_index, out_valid_r && out_last_r, 7'(out_idx_r) == k_last)

endmodule

@@ test/kmeans_2d_grid_snap_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmeans_2d_grid_snap_tb
// Loads points and initial centroids, runs clustering starts under several
// register settings and flow-control patterns, and compares every reported
// centroid word against a behavioral k-means predictor with grid snap.
// ----------------------------------------------------------------------------
module kmeans_2d_grid_snap_tb;

  localparam int POINT_CAP = 65536;
  localparam int CLUSTER_CAP = 64;

  typedef struct packed {
    logic [5:0]         idx;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [16:0]        count;
    logic               del;
    logic               last;
  } centroid_word_t;

  class kmeans_scoreboard;
    int k_reg, epoch_reg, snap_reg, step_reg, min_reg;
    int px[$];
    int py[$];
    int cx[CLUSTER_CAP];
    int cy[CLUSTER_CAP];
    int cent_loaded;
    centroid_word_t pending[$];
    int errors;

    function new();
      k_reg = 64;
      epoch_reg = 10;
      snap_reg = 1;
      step_reg = 150;
      min_reg = 20;
      cent_loaded = 0;
      errors = 0;
      foreach (cx[i]) begin
        cx[i] = 0;
        cy[i] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, int val);
      case (idx)
        kmgs_pkg::REG_NUM_CLUSTERS: k_reg = val & 'h7f;
        kmgs_pkg::REG_EPOCHS: epoch_reg = val & 'hff;
        kmgs_pkg::REG_SNAP_MODE: snap_reg = val & 'h3;
        kmgs_pkg::REG_GRID_STEP: step_reg = val & 'hffff;
        kmgs_pkg::REG_MIN_SIZE: min_reg = val & 'h1ffff;
        default: ;
      endcase
    endfunction

    function int grid_snap(int v);
      longint ip, r, o;
      if (step_reg == 0) return v;
      ip = longint'(v) / 16;
      r = ip % longint'(step_reg);
      o = longint'(v) - r * 16;
      if (2 * r > step_reg) o += longint'(step_reg) * 16;
      if (o > 8388607) o = 8388607;
      if (o < -8388608) o = -8388608;
      return int'(o);
    endfunction

    function void note_word(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y);
      int k, ep, i, c, best;
      longint sx[CLUSTER_CAP];
      longint sy[CLUSTER_CAP];
      int tally[CLUSTER_CAP];
      longint dx, dy, d, best_d;
      centroid_word_t w;
      if (op == kmgs_pkg::OP_LOAD_POINT) begin
        if (px.size() < POINT_CAP) begin
          px.insert(px.size(), int'(x));
          py.insert(py.size(), int'(y));
        end
        return;
      end
      if (op == kmgs_pkg::OP_LOAD_CENTROID) begin
        if (cent_loaded < CLUSTER_CAP) begin
          cx[cent_loaded] = int'(x);
          cy[cent_loaded] = int'(y);
          cent_loaded++;
        end
        return;
      end
      if (op != kmgs_pkg::OP_START) return;
      k = (k_reg == 0) ? 1 : (k_reg > CLUSTER_CAP ? CLUSTER_CAP : k_reg);
      foreach (tally[j]) tally[j] = 0;
      for (ep = 0; ep < epoch_reg; ep++) begin
        foreach (tally[j]) begin
          tally[j] = 0;
          sx[j] = 0;
          sy[j] = 0;
        end
        for (i = 0; i < px.size(); i++) begin
          best = 0;
          best_d = (longint'(1) << 50) - 1;
          for (c = 0; c < k; c++) begin
            dx = longint'(px[i]) - cx[c];
            dy = longint'(py[i]) - cy[c];
            d = dx * dx + dy * dy;
            if (d < best_d) begin
              best_d = d;
              best = c;
            end
          end
          sx[best] += px[i];
          sy[best] += py[i];
          tally[best]++;
        end
        for (c = 0; c < k; c++) begin
          if (tally[c] != 0) begin
            cx[c] = int'(sx[c] / tally[c]);
            cy[c] = int'(sy[c] / tally[c]);
            if (snap_reg[0]) cx[c] = grid_snap(cx[c]);
            if (snap_reg[1]) cy[c] = grid_snap(cy[c]);
          end
        end
      end
      for (c = 0; c < k; c++) begin
        w.idx = 6'(c);
        w.count = 17'(tally[c]);
        w.del = tally[c] < min_reg;
        w.cx = w.del ? -24'sd16 : 24'(cx[c]);
        w.cy = w.del ? -24'sd16 : 24'(cy[c]);
        w.last = (c == k - 1);
        pending.insert(pending.size(), w);
      end
    endfunction

    function void check_result(centroid_word_t got);
      centroid_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, got %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  kmgs_in_if in_ch();
  kmgs_out_if out_ch();

  kmeans_2d_grid_snap dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kmeans_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.cluster_index, out_ch.centroid_x, out_ch.centroid_y,
                         out_ch.member_count, out_ch.deleted, out_ch.last});
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(op, x, y);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_all(int k, int ep, int snap, int step, int min_sz);
    in_ch.valid <= 1'b0;
    reg_write(kmgs_pkg::REG_NUM_CLUSTERS, k);
    reg_write(kmgs_pkg::REG_EPOCHS, ep);
    reg_write(kmgs_pkg::REG_SNAP_MODE, snap);
    reg_write(kmgs_pkg::REG_GRID_STEP, step);
    reg_write(kmgs_pkg::REG_MIN_SIZE, min_sz);
  endtask

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(3) == 0) return 24'($urandom());
    return $signed(24'($urandom_range(8000))) - 24'sd4000 +
           ($urandom_range(1) ? 24'sd40000 : -24'sd40000);
  endfunction

  function automatic int pick(int a, int b, int c, int d);
    case ($urandom_range(3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  initial begin
    int ph, n, lim;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= kmgs_pkg::OP_LOAD_POINT;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_all(2, 1, 3, 2, 0);
    send_word(kmgs_pkg::OP_LOAD_CENTROID, 24'sh7fffff, 24'sh7fffff);
    send_word(kmgs_pkg::OP_LOAD_CENTROID, -24'sh800000, -24'sh800000);
    send_word(kmgs_pkg::OP_LOAD_CENTROID, 24'sd0, 24'sd0);
    send_word(kmgs_pkg::OP_LOAD_CENTROID, -24'sd16, 24'sd16);
    send_word(kmgs_pkg::OP_LOAD_POINT, 24'sh7fffff, 24'sh7fffff);
    send_word(kmgs_pkg::OP_LOAD_POINT, -24'sh800000, -24'sh800000);
    send_word(kmgs_pkg::OP_LOAD_POINT, 24'sh7fffff, -24'sh800000);
    send_word(kmgs_pkg::OP_LOAD_POINT, -24'sh800000, 24'sh7fffff);
    send_word(kmgs_pkg::OP_LOAD_POINT, 24'sd0, 24'sd0);
    send_word(kmgs_pkg::OP_LOAD_POINT, -24'sd1, -24'sd1);
    send_word(kmgs_pkg::OP_LOAD_POINT, 24'sd17, -24'sd17);
    send_word(kmgs_pkg::OP_LOAD_POINT, 24'sh7ffffa, 24'sh7fff00);
    send_word(kmgs_pkg::OP_RESERVED, 24'sh123456, -24'sd5);
    send_word(kmgs_pkg::OP_START, 24'sd0, 24'sd0);
    drain();
    set_all(4, 0, 0, 150, 1);
    send_word(kmgs_pkg::OP_START, 24'sd0, 24'sd0);
    drain();
    set_all(1, 255, 3, 0, 0);
    send_word(kmgs_pkg::OP_START, 24'sd0, 24'sd0);
    drain();
    set_all(4, 2, 1, 65535, 3);
    send_word(kmgs_pkg::OP_START, 24'sd0, 24'sd0);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 13 : 83) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 13 : 83) : 0;
      lim = (sb.cent_loaded < 8) ? sb.cent_loaded : 8;
      set_all($urandom_range(lim, 1), $urandom_range(3, 1), $urandom_range(3),
              pick(2, 65535, 150, $urandom_range(65535)),
              pick(0, 65536, 2, $urandom_range(6)));
      if (ph == 2) hold_cycles = 20000;
      for (n = 0; n < 12; n++) begin
        if (n == 5 || n == 11) begin
          send_word(kmgs_pkg::OP_START, 24'($urandom()), 24'($urandom()));
        end else if ($urandom_range(9) == 0) begin
          send_word($urandom_range(1) ? kmgs_pkg::OP_RESERVED : kmgs_pkg::OP_LOAD_CENTROID,
                    rand_coord(), rand_coord());
        end else begin
          send_word(kmgs_pkg::OP_LOAD_POINT, rand_coord(), rand_coord());
        end
      end
      drain();
    end

    send_idle_pct = 13;
    recv_stall_pct = 13;
    while (sb.cent_loaded < CLUSTER_CAP) begin
      send_word(kmgs_pkg::OP_LOAD_CENTROID, rand_coord(), rand_coord());
    end
    send_word(kmgs_pkg::OP_LOAD_CENTROID, 24'sd160, 24'sd160);
    set_all(0, 2, 2, 150, 2);
    send_word(kmgs_pkg::OP_START, 24'sd0, 24'sd0);
    drain();
    set_all(127, 1, 3, 7, 1);
    send_word(kmgs_pkg::OP_START, 24'sd0, 24'sd0);
    drain();
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
